>>> rtl/rfpq_pkg.sv
// Package for the rectangle-flip / point-query bit tree unit.
// Holds the grid constants, operation codes, walker structs and the lowest-set-bit helper.
// No dependencies; rfpq_walk and the top level import it.
package rfpq_pkg;

  // Rows and columns held in the tree store.
  localparam int GRID = 1024;
  localparam int ADDR_W = $clog2(GRID);
  // Width of the coordinate fields and of the size register.
  localparam int FIELD_W = 11;
  // Walk indices need one more bit: a corner may be a field value plus one.
  localparam int WALK_W = FIELD_W + 1;

  localparam int IN_TDATA_W = ((4 * FIELD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [FIELD_W-1:0] GRID_SIZE_RESET = FIELD_W'(1024);

  typedef logic [1:0] op_t;
  localparam op_t OP_TOGGLE = 2'd0;
  localparam op_t OP_QUERY = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [WALK_W-1:0] walk_idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic      start;
    logic      up;
    walk_idx_t row;
    walk_idx_t col;
    field_t    lim;
  } walk_cmd_t;

  typedef struct packed {
    logic  valid;
    addr_t row;
    addr_t col;
  } walk_node_t;

  function automatic walk_idx_t low_bit(walk_idx_t v);
    return v & (~v + 1'b1);
  endfunction

endpackage

>>> rtl/rfpq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// A read and a write to the same address in one cycle return the old contents.
// No dependencies.
module rfpq_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 1024,
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rfpq_walk.sv
// Index walker: steps through the tree nodes of one corner, one node per cycle.
// Upward walks add the lowest set bit, downward walks subtract it, in both dimensions.
// Depends on rfpq_pkg.
module rfpq_walk (
  input  logic                clk,
  input  logic                rst,
  input  rfpq_pkg::walk_cmd_t cmd,
  output rfpq_pkg::walk_node_t node,
  output logic                busy
);
  import rfpq_pkg::*;

  localparam logic [WALK_W:0] GRID_X = (WALK_W + 1)'(GRID);

  logic      active;
  logic      up;
  walk_idx_t i;
  walk_idx_t j;
  walk_idx_t c0;
  field_t    lim;

  walk_idx_t lim_w;
  walk_idx_t j_up;
  walk_idx_t i_up;
  walk_idx_t j_dn;
  walk_idx_t i_dn;
  logic      skip_row;
  logic      emit;
  logic      ok_start;

  always_comb begin
    lim_w = {1'b0, lim};
    j_up = j + low_bit(j);
    i_up = i + low_bit(i);
    j_dn = j - low_bit(j);
    i_dn = i - low_bit(i);
    // Rows beyond the store hold nothing, so a downward walk passes them whole.
    skip_row = {1'b0, i} > GRID_X;
    emit = up ? 1'b1 : (!skip_row && ({1'b0, j} <= GRID_X));
    ok_start = (cmd.row != '0) && (cmd.col != '0) &&
               (!cmd.up || ((cmd.row <= {1'b0, cmd.lim}) && (cmd.col <= {1'b0, cmd.lim})));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (active) begin
      if (up) begin
        if (j_up <= lim_w) begin
          j <= j_up;
        end else if (i_up <= lim_w) begin
          i <= i_up;
          j <= c0;
        end else begin
          active <= 1'b0;
        end
      end else begin
        if (!skip_row && (j_dn != '0)) begin
          j <= j_dn;
        end else if (i_dn != '0) begin
          i <= i_dn;
          j <= c0;
        end else begin
          active <= 1'b0;
        end
      end
    end else if (cmd.start) begin
      active <= ok_start;
      up <= cmd.up;
      i <= cmd.row;
      j <= cmd.col;
      c0 <= cmd.col;
      lim <= cmd.lim;
    end
  end

  assign busy = active;
  assign node.valid = active & emit;
  assign node.row = ADDR_W'(i - 1'b1);
  assign node.col = ADDR_W'(j - 1'b1);

endmodule

>>> rtl/rect_flip_point_query_bit_tree_unit.sv
// Top level of the rectangle-flip / point-query bit tree unit.
// Depends on rfpq_pkg, rfpq_ram and rfpq_walk.
//
// Usage: words arrive on the s_axis channel. s_axis_tuser carries the operation
// (toggle rectangle, query point, clear grid) and s_axis_tdata the coordinates.
// Only a query produces a result word on m_axis, the cell bit in bit 0. The user
// must write the size register via cfg_wr_en / cfg_wr_data while idle; unchecked.
//
// The tree lives in one synchronous RAM of GRID rows, each a whole row of node
// bits. Nodes are read at one node per cycle, and a toggle flips each and
// writes it back; a row written in the cycle that the next read of the same
// row is issued is forwarded from a one-entry bypass register. A toggle walks
// its four corners in turn and a query walks one; a walk visits at most
// (log2(GRID) + 1)^2 nodes. A clear writes one row per cycle. After reset the
// block runs the same clearing pass with s_axis_tready low and the size
// register at 1024. A result that is not taken waits in the output register;
// the next word is still accepted, and a later query holds its answer until
// the output register is free.
module rect_flip_point_query_bit_tree_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [rfpq_pkg::FIELD_W-1:0]     cfg_wr_data,  // grid_size
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // row_lo [10:0], col_lo [21:11], row_hi [32:22], col_hi [43:33], zero fill
  input  logic [rfpq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // cell_value [0], zero fill
  output logic [rfpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import rfpq_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TOGGLE,
    ST_QUERY
  } state_t;

  typedef logic [GRID-1:0] row_word_t;

  state_t     state;
  addr_t      clr_row;
  field_t     grid_size;
  field_t     row_lo;
  field_t     col_lo;
  field_t     row_hi;
  field_t     col_hi;
  logic [2:0] corner;
  logic       acc;
  logic       out_bit;

  // Read pipeline stage and write bypass.
  logic      rd_pending;
  addr_t     rd_row;
  addr_t     rd_col;
  logic      fwd_valid;
  addr_t     fwd_row;
  row_word_t fwd_data;

  row_word_t  rd_data;
  row_word_t  cur_word;
  row_word_t  flip_word;
  logic       cur_bit;
  logic       we;
  addr_t      waddr;
  row_word_t  wdata;
  field_t     lim;
  logic [2:0] last_corner;
  logic       walk_busy;
  logic       walk_done;
  logic       in_accept;
  logic       res_load;
  walk_cmd_t  walk_cmd;
  walk_node_t walk_node;

  always_comb begin
    // The size in use is the register limited to the store.
    lim = (int'(grid_size) > GRID) ? FIELD_W'(GRID) : grid_size;
    last_corner = (state == ST_QUERY) ? 3'd1 : 3'd4;

    walk_cmd.start = (state inside {ST_TOGGLE, ST_QUERY}) && !walk_busy &&
                     (corner != last_corner);
    walk_cmd.up = (state == ST_TOGGLE);
    // Corners in order: (lo,lo), (lo,hi+1), (hi+1,lo), (hi+1,hi+1).
    walk_cmd.row = corner[1] ? ({1'b0, row_hi} + 1'b1) : {1'b0, row_lo};
    walk_cmd.col = corner[0] ? ({1'b0, col_hi} + 1'b1) : {1'b0, col_lo};
    walk_cmd.lim = lim;

    walk_done = (corner == last_corner) && !walk_busy && !rd_pending;
    // A finished query loads its answer once the output register is free.
    res_load = (state == ST_QUERY) && walk_done && (!m_axis_tvalid || m_axis_tready);

    cur_word = (fwd_valid && (fwd_row == rd_row)) ? fwd_data : rd_data;
    cur_bit = cur_word[rd_col];
    flip_word = cur_word;
    flip_word[rd_col] = ~cur_bit;

    if (state == ST_CLEAR) begin
      we = 1'b1;
      waddr = clr_row;
      wdata = '0;
    end else begin
      we = rd_pending && (state == ST_TOGGLE);
      waddr = rd_row;
      wdata = flip_word;
    end

    s_axis_tready = (state == ST_IDLE);
    in_accept = s_axis_tvalid && s_axis_tready;
    m_axis_tdata = {(OUT_TDATA_W - 1)'(0), out_bit};
  end

  rfpq_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .cmd  (walk_cmd),
    .node (walk_node),
    .busy (walk_busy)
  );

  rfpq_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (GRID),
    .DEPTH  (GRID)
  ) u_tree (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (walk_node.row),
    .rdata (rd_data)
  );

  // Read stage and bypass register; payload only, apart from the valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      rd_pending <= walk_node.valid;
      fwd_valid <= we;
    end
    rd_row <= walk_node.row;
    rd_col <= walk_node.col;
    fwd_row <= waddr;
    fwd_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_row <= '0;
      grid_size <= GRID_SIZE_RESET;
      m_axis_tvalid <= 1'b0;
      corner <= '0;
    end else begin
      if (cfg_wr_en) begin
        grid_size <= cfg_wr_data;
      end
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (walk_cmd.start) begin
        corner <= corner + 1'b1;
      end

      case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ADDR_W'(GRID - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            row_lo <= s_axis_tdata[FIELD_W-1:0];
            col_lo <= s_axis_tdata[2*FIELD_W-1:FIELD_W];
            row_hi <= s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
            col_hi <= s_axis_tdata[4*FIELD_W-1:3*FIELD_W];
            corner <= '0;
            acc <= 1'b0;
            case (s_axis_tuser)
              OP_TOGGLE: state <= ST_TOGGLE;
              OP_QUERY:  state <= ST_QUERY;
              OP_CLEAR: begin
                clr_row <= '0;
                state <= ST_CLEAR;
              end
              default:   state <= ST_IDLE;
            endcase
          end
        end
        ST_TOGGLE: begin
          if (walk_done) begin
            state <= ST_IDLE;
          end
        end
        ST_QUERY: begin
          if (rd_pending) begin
            acc <= acc ^ cur_bit;
          end
          // Hand the parity over once the walk has drained and the output is free.
          if (res_load) begin
            out_bit <= acc;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
